@@ hw/rtl/hscd_pkg.sv @@
// shared types and constants for the header synced command deframer
package hscd_pkg;

  localparam logic [7:0] HdrRun    = 8'hFF;
  localparam logic [7:0] HdrEnd    = 8'hFD;
  localparam logic [7:0] Broadcast = 8'hFF;
  localparam logic [7:0] CmdFirst  = 8'h01;
  localparam logic [7:0] CmdLast   = 8'h06;

  // run of 0xff bytes saturates here
  localparam logic [1:0] FfSat = 2'd2;

  // payload bytes that the decoder looks at
  localparam int unsigned DecodeBytes = 4;

  typedef enum logic [2:0] {
    ActNone       = 3'd0,
    ActStatus     = 3'd1,
    ActDarkMode   = 3'd2,
    ActOpto       = 3'd3,
    ActHertz      = 3'd4,
    ActPulseWidth = 3'd5,
    ActReturnId   = 3'd6
  } action_e;

  typedef struct packed {
    logic        packet_done;
    logic        addressed;
    action_e     action;
    logic [7:0]  arg_first;
    logic [7:0]  arg_second;
    logic [15:0] arg_word;
    logic        line_error;
  } res_t;

endpackage

@@ hw/rtl/header_synced_command_deframer_core.sv @@
// top level of the header synced command deframer: input stage, parser and result register
//
// Receives serial bytes with their overrun and framing flags on the input
// channel and gives one result per byte on the output channel, both with
// valid/ready; a transfer happens when valid and ready are both high.
// A packet is two or more 0xff bytes, 0xfd, then PACKET_BYTES-3 payload
// bytes; the last payload byte gives packet_done with the decoded address
// match, action and argument bytes. A byte with a line error resets the
// parser and gives line_error only.
// Between an input transfer and out_valid_o lie the input register and then
// the result register. Throughput: one byte per cycle while the receiver
// takes results, set by the combinational parser step between the registers.
// A stalled receiver holds the result register; the input register still
// takes one more byte, after which in_ready_o drops until the result moves.
// The device id is written on the cfg channel, which is always ready; write
// it only with no byte in flight. Reset clears the parser, both valid flags
// and the device id (to 0).
module header_synced_command_deframer_core #(
  parameter int unsigned PACKET_BYTES = 9
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_device_id_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        overrun_error_i,
  input  logic        framing_error_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        packet_done_o,
  output logic        addressed_o,
  output logic [2:0]  action_o,
  output logic [7:0]  arg_first_o,
  output logic [7:0]  arg_second_o,
  output logic [15:0] arg_word_o,
  output logic        line_error_o
);

  logic           device_id_q;
  logic [7:0]     dev_id_q;
  logic           s1_valid_q;
  logic [7:0]     s1_byte_q;
  logic           s1_ovr_q, s1_frm_q;
  logic           out_valid_q;
  hscd_pkg::res_t res_q, res_d;
  logic           advance;

  assign cfg_ready_o = 1'b1;
  assign advance     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_id_q    <= '0;
      device_id_q <= 1'b0;
    end else if (cfg_valid_i) begin
      dev_id_q    <= cfg_device_id_i;
      device_id_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q <= rx_byte_i;
      s1_ovr_q  <= overrun_error_i;
      s1_frm_q  <= framing_error_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  hscd_parser #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance),
    .device_id_i     (device_id_q ? dev_id_q : 8'h00),
    .rx_byte_i       (s1_byte_q),
    .overrun_error_i (s1_ovr_q),
    .framing_error_i (s1_frm_q),
    .res_o           (res_d)
  );

  assign out_valid_o   = out_valid_q;
  assign packet_done_o = res_q.packet_done;
  assign addressed_o   = res_q.addressed;
  assign action_o      = res_q.action;
  assign arg_first_o   = res_q.arg_first;
  assign arg_second_o  = res_q.arg_second;
  assign arg_word_o    = res_q.arg_word;
  assign line_error_o  = res_q.line_error;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(res_q))
    else $error("result changed while the receiver stalled");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(s1_byte_q))
    else $error("held input byte lost before the parser took it");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("parser step without a result");

endmodule

@@ hw/rtl/hscd_parser.sv @@
// header detector, payload capture and command decode for one received byte
module hscd_parser #(
  parameter int unsigned PACKET_BYTES = 9
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         device_id_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               overrun_error_i,
  input  logic               framing_error_i,
  output hscd_pkg::res_t     res_o
);

  localparam int unsigned PayloadBytes = PACKET_BYTES - 3;
  localparam int unsigned IdxW         = $clog2(PayloadBytes);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(PayloadBytes - 1);

  logic [1:0]      ff_q, ff_d, ff_mid;
  logic            in_packet_q, in_packet_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      store_q [hscd_pkg::DecodeBytes];
  logic [7:0]      store_d [hscd_pkg::DecodeBytes];
  logic            err, done, hit;
  logic [7:0]      addr_b, cmd_b;

  assign err = overrun_error_i | framing_error_i;

  // capture bypass: the completing byte may itself be a decoded byte
  always_comb begin
    for (int k = 0; k < hscd_pkg::DecodeBytes; k++) begin
      store_d[k] = (in_packet_q && idx_q == IdxW'(k)) ? rx_byte_i : store_q[k];
    end
  end

  always_comb begin
    ff_d        = ff_q;
    ff_mid      = ff_q;
    in_packet_d = in_packet_q;
    idx_d       = idx_q;
    done        = 1'b0;
    if (err) begin
      ff_d        = '0;
      in_packet_d = 1'b0;
      idx_d       = '0;
    end else begin
      if (in_packet_q) begin
        if (idx_q == LastIdx) begin
          done        = 1'b1;
          ff_mid      = '0;
          in_packet_d = 1'b0;
          idx_d       = '0;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      // header check runs on every byte without a line error, payload included
      if (rx_byte_i == hscd_pkg::HdrRun) begin
        ff_d = (ff_mid == hscd_pkg::FfSat) ? ff_mid : ff_mid + 2'd1;
      end else if (rx_byte_i == hscd_pkg::HdrEnd) begin
        if (ff_mid == hscd_pkg::FfSat) begin
          in_packet_d = 1'b1;
          idx_d       = '0;
        end
        ff_d = '0;
      end else begin
        ff_d = '0;
      end
    end
  end

  assign addr_b = store_d[0];
  assign cmd_b  = store_d[1];
  assign hit    = (addr_b == device_id_i) || (addr_b == hscd_pkg::Broadcast);

  always_comb begin
    res_o = '0;
    if (err) begin
      res_o.line_error = 1'b1;
    end else if (done) begin
      res_o.packet_done = 1'b1;
      res_o.addressed   = hit;
      if (hit && (cmd_b inside {[hscd_pkg::CmdFirst:hscd_pkg::CmdLast]})) begin
        res_o.action = hscd_pkg::action_e'(cmd_b[2:0]);
      end
      res_o.arg_first  = store_d[2];
      res_o.arg_second = store_d[3];
      res_o.arg_word   = {store_d[2], store_d[3]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ff_q        <= '0;
      in_packet_q <= 1'b0;
      idx_q       <= '0;
    end else if (step_i) begin
      ff_q        <= ff_d;
      in_packet_q <= in_packet_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && !err) begin
      for (int k = 0; k < hscd_pkg::DecodeBytes; k++) begin
        store_q[k] <= store_d[k];
      end
    end
  end

  a_ff_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ff_q != 2'd3)
    else $error("ff run count beyond saturation");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= LastIdx)
    else $error("payload index past last byte");

  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_packet_q |-> idx_q == '0)
    else $error("payload index not cleared outside a packet");

  a_err_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && err |=> !in_packet_q && ff_q == '0)
    else $error("line error did not reset the parser");

  a_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_o.packet_done && res_o.line_error))
    else $error("completion and line error on the same byte");

endmodule

@@ tb/sv/tb.sv @@
// testbench for the header synced command deframer core
`timescale 1ns / 100ps

module tb;

  localparam int unsigned PacketBytes  = 9;
  localparam int unsigned PayloadBytes = PacketBytes - 3;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned DrainCycles  = 4;
  localparam int unsigned HoldCycles   = 300;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_device_id_i = 8'h00;
  logic        in_valid_i      = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i       = 8'h00;
  logic        overrun_error_i = 1'b0;
  logic        framing_error_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i     = 1'b0;
  logic        packet_done_o;
  logic        addressed_o;
  logic [2:0]  action_o;
  logic [7:0]  arg_first_o;
  logic [7:0]  arg_second_o;
  logic [15:0] arg_word_o;
  logic        line_error_o;

  // parser state mirrored for prediction
  logic [1:0]  ff_run     = 2'd0;
  logic        collecting = 1'b0;
  int unsigned stored     = 0;
  logic [7:0]  payload_q [PayloadBytes];
  logic [7:0]  dev_id     = 8'h00;

  hscd_pkg::res_t awaited_decodes [$];
  int unsigned items_sent  = 0;
  int unsigned failures    = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_pct    = 0;
  int unsigned stall_pct   = 0;
  logic        hold_rx     = 1'b0;

  header_synced_command_deframer_core #(
    .PACKET_BYTES(PacketBytes)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_device_id_i(cfg_device_id_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .overrun_error_i(overrun_error_i),
    .framing_error_i(framing_error_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .packet_done_o  (packet_done_o),
    .addressed_o    (addressed_o),
    .action_o       (action_o),
    .arg_first_o    (arg_first_o),
    .arg_second_o   (arg_second_o),
    .arg_word_o     (arg_word_o),
    .line_error_o   (line_error_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= !hold_rx && ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic hscd_pkg::res_t deframe_byte(input logic [7:0] b, input logic ovr,
                                                  input logic frm);
    hscd_pkg::res_t r;
    logic done;
    logic hit;
    r = '0;
    done = 1'b0;
    if (ovr || frm) begin
      ff_run = 2'd0;
      collecting = 1'b0;
      stored = 0;
      r.line_error = 1'b1;
      return r;
    end
    if (collecting) begin
      if (stored < PayloadBytes) payload_q[stored] = b;
      stored++;
      if (stored >= PayloadBytes) begin
        done = 1'b1;
        ff_run = 2'd0;
        collecting = 1'b0;
      end
    end
    // completing byte is still seen by the header detector
    if (b == hscd_pkg::HdrRun) begin
      if (ff_run < hscd_pkg::FfSat) ff_run++;
    end else if (b == hscd_pkg::HdrEnd) begin
      if (ff_run >= hscd_pkg::FfSat) begin
        collecting = 1'b1;
        stored = 0;
      end
      ff_run = 2'd0;
    end else begin
      ff_run = 2'd0;
    end
    if (done) begin
      hit = (payload_q[0] == dev_id) || (payload_q[0] == hscd_pkg::Broadcast);
      r.packet_done = 1'b1;
      r.addressed = hit;
      r.action = (hit && payload_q[1] >= hscd_pkg::CmdFirst &&
                  payload_q[1] <= hscd_pkg::CmdLast) ?
                 hscd_pkg::action_e'(payload_q[1][2:0]) : hscd_pkg::ActNone;
      r.arg_first = payload_q[2];
      r.arg_second = payload_q[3];
      r.arg_word = {payload_q[2], payload_q[3]};
    end
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk_i) begin
    hscd_pkg::res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_decodes.size() == 0) begin
        $display("%0t: result transfer with nothing expected, expected none actual %b",
                 $time, packet_done_o);
        failures++;
      end else begin
        want = awaited_decodes.pop_front();
        compare_field("packet_done", 16'(want.packet_done), 16'(packet_done_o));
        compare_field("addressed", 16'(want.addressed), 16'(addressed_o));
        compare_field("action", 16'(want.action), 16'(action_o));
        compare_field("arg_first", 16'(want.arg_first), 16'(arg_first_o));
        compare_field("arg_second", 16'(want.arg_second), 16'(arg_second_o));
        compare_field("arg_word", want.arg_word, arg_word_o);
        compare_field("line_error", 16'(want.line_error), 16'(line_error_o));
      end
    end
  end

  // leaves valid high on return; the caller sends again or drains
  task automatic send_rx_byte(input logic [7:0] b, input logic ovr, input logic frm);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    overrun_error_i <= ovr;
    framing_error_i <= frm;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    awaited_decodes.push_back(deframe_byte(b, ovr, frm));
    items_sent++;
  endtask

  // clean bytes, first byte in the most significant position
  task automatic send_clean_run(input logic [8*16-1:0] bytes, input int unsigned n);
    for (int i = 0; i < n; i++) send_rx_byte(bytes[8*(n-1-i) +: 8], 1'b0, 1'b0);
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (awaited_decodes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_device_id(input logic [7:0] id);
    cfg_valid_i <= 1'b1;
    cfg_device_id_i <= id;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    dev_id = id;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random_packet();
    int unsigned run_len;
    int unsigned pick;
    logic [7:0] body [PayloadBytes];
    logic [1:0] flags;
    run_len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 4);
    repeat (run_len) send_rx_byte(hscd_pkg::HdrRun, 1'b0, 1'b0);
    send_rx_byte(hscd_pkg::HdrEnd, 1'b0, 1'b0);
    pick = $urandom_range(0, 99);
    body[0] = (pick < 40) ? dev_id : (pick < 65) ? hscd_pkg::Broadcast :
              8'($urandom_range(0, 255));
    body[1] = ($urandom_range(0, 99) < 70) ?
              8'($urandom_range(hscd_pkg::CmdFirst, hscd_pkg::CmdLast)) :
              8'($urandom_range(0, 255));
    for (int i = 2; i < PayloadBytes; i++) body[i] = 8'($urandom_range(0, 255));
    // header inside the payload restarts collection
    if ($urandom_range(0, 29) == 0) begin
      body[1] = hscd_pkg::HdrRun;
      body[2] = hscd_pkg::HdrRun;
      body[3] = hscd_pkg::HdrEnd;
    end
    for (int i = 0; i < PayloadBytes; i++) begin
      if ($urandom_range(0, 49) == 0) begin
        flags = 2'($urandom_range(1, 3));
        send_rx_byte(body[i], flags[0], flags[1]);
        return;
      end
      send_rx_byte(body[i], 1'b0, 1'b0);
    end
  endtask

  task automatic send_noise();
    logic [1:0] flags;
    repeat ($urandom_range(1, 3)) begin
      flags = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(1, 3)) : 2'b00;
      send_rx_byte(8'($urandom_range(0, 255)), flags[0], flags[1]);
    end
  endtask

  task automatic test_decode_directed();
    // device id still at reset; long ff run, last payload byte starts a new run
    send_clean_run(128'({8'hFF, 8'hFF, 8'hFF, 8'hFD, 8'h00, 8'h01, 8'h00, 8'h00,
                         8'h12, 8'hFF}), 10);
    // run continued from completion, address misses, argument bytes at max
    send_clean_run(128'({8'hFF, 8'hFD, 8'h34, 8'h06, 8'hFF, 8'hFF, 8'hFF, 8'hFF}), 8);
    // reopened by a header in the payload, broadcast with an unknown command
    send_clean_run(128'({8'hFF, 8'hFF, 8'hFD, 8'hFF, 8'hFF, 8'hFD,
                         8'hFF, 8'h07, 8'h80, 8'h01, 8'h00, 8'h00}), 12);
    wait_drain();
  endtask

  task automatic test_line_errors();
    send_rx_byte(8'hFF, 1'b0, 1'b0);
    send_rx_byte(8'hFF, 1'b0, 1'b0);
    send_rx_byte(8'hFD, 1'b1, 1'b0);
    send_rx_byte(8'hFD, 1'b0, 1'b0);
    send_clean_run(128'({8'hFF, 8'hFF, 8'hFD, 8'h00}), 4);
    send_rx_byte(8'h55, 1'b0, 1'b1);
    send_clean_run(128'({8'h01, 8'h02, 8'h03, 8'h04}), 4);
    send_rx_byte(8'hAA, 1'b1, 1'b1);
    wait_drain();
  endtask

  task automatic test_random_phase(input int unsigned idle, input int unsigned stall,
                                   input logic [7:0] id, input int unsigned n);
    int unsigned start_count;
    wait_drain();
    write_device_id(id);
    idle_pct = idle;
    stall_pct = stall;
    start_count = items_sent;
    while (items_sent - start_count < n) begin
      if ($urandom_range(0, 99) < 30) send_noise();
      send_random_packet();
    end
    wait_drain();
  endtask

  // receiver holds off long enough for the input side to back up
  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    fork
      begin
        hold_rx <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_rx <= 1'b0;
      end
    join_none
    repeat (4) send_random_packet();
    wait_drain();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_decode_directed();
    test_line_errors();
    test_random_phase(0, 0, 8'h00, 140);
    test_random_phase(77, 0, 8'hFF, 140);
    test_random_phase(0, 77, 8'($urandom_range(1, 254)), 140);
    test_random_phase(22, 22, 8'($urandom_range(0, 255)), 140);
    test_backpressure();
    wait_drain();
    repeat (10) @(posedge clk_i);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
